// ----- hdl/ccsr_pkg.sv -----
package ccsr_pkg;

  localparam int unsigned MAX_WIDTH_DEF  = 64;
  localparam int unsigned MAX_HEIGHT_DEF = 64;

  localparam int unsigned OP_W       = 3;
  localparam int unsigned COORD_W    = 6;
  localparam int unsigned CHAR_W     = 8;
  localparam int unsigned SIZE_W     = 7;
  localparam int unsigned STATUS_W   = 2;
  localparam int unsigned IN_DATA_W  = 40;
  localparam int unsigned OUT_DATA_W = 16;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 8;

  localparam logic [OP_W-1:0] OP_POINT   = 3'd0;
  localparam logic [OP_W-1:0] OP_FILL    = 3'd1;
  localparam logic [OP_W-1:0] OP_OUTLINE = 3'd2;
  localparam logic [OP_W-1:0] OP_CIRCLE  = 3'd3;
  localparam logic [OP_W-1:0] OP_CLEAR   = 3'd4;
  localparam logic [OP_W-1:0] OP_READ    = 3'd5;

  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_CLIP  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BLANK  = 2'd2;

  localparam logic [SIZE_W-1:0] WIDTH_RESET  = 7'd64;
  localparam logic [SIZE_W-1:0] HEIGHT_RESET = 7'd64;
  localparam logic [CHAR_W-1:0] BLANK_RESET  = 8'd32;

  typedef struct packed {
    logic [CHAR_W-1:0]  pen_char;
    logic [COORD_W-1:0] radius;
    logic [COORD_W-1:0] y_second;
    logic [COORD_W-1:0] x_second;
    logic [COORD_W-1:0] y_first;
    logic [COORD_W-1:0] x_first;
  } in_beat_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [CHAR_W-1:0]   read_value;
  } out_beat_t;

  typedef enum logic [1:0] {
    SH_FILL    = 2'd0,
    SH_OUTLINE = 2'd1,
    SH_CIRCLE  = 2'd2
  } shape_t;

endpackage

// ----- hdl/char_canvas_shape_rasterizer.sv -----
// Character framebuffer of MAX_HEIGHT rows by MAX_WIDTH columns held in one
// single-port-write RAM, with a synchronous read port used by the read command.
// After reset the block fills every RAM entry with BLANK_RESET (not the
// configured blank) and takes no command beat until that pass is done.
// Point, rectangle, circle and clear commands walk their bounding box one
// pixel per cycle through the write port: a point its single pixel, a
// rectangle (x_second - x_first + 1) by (y_second - y_first + 1) pixels, a
// circle a square of side 2 * radius + 1, a clear canvas_width by
// canvas_height pixels. A read, an empty rectangle and an unused opcode walk
// nothing. The done state moves the result into the output register once it
// is free; the next command beat is taken while the result waits on out_tready.
module char_canvas_shape_rasterizer #(
  parameter int unsigned MAX_WIDTH  = ccsr_pkg::MAX_WIDTH_DEF,
  parameter int unsigned MAX_HEIGHT = ccsr_pkg::MAX_HEIGHT_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  // x_first, y_first, x_second, y_second, radius, pen_char, zero pad.
  input  logic [ccsr_pkg::IN_DATA_W-1:0]     in_tdata,
  // opcode.
  input  logic [ccsr_pkg::OP_W-1:0]          in_tuser,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // read_value, status, zero pad.
  output logic [ccsr_pkg::OUT_DATA_W-1:0]    out_tdata,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [ccsr_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [ccsr_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import ccsr_pkg::*;

  localparam int unsigned DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int unsigned AW    = $clog2(DEPTH);

  typedef enum logic [4:0] {
    S_INIT = 5'b00001,
    S_IDLE = 5'b00010,
    S_SCAN = 5'b00100,
    S_READ = 5'b01000,
    S_DONE = 5'b10000
  } state_t;

  logic [CHAR_W-1:0] mem [DEPTH];

  state_t                state_r, state_nxt;
  logic [AW-1:0]         init_addr_r, init_addr_nxt;
  logic [SIZE_W-1:0]     cfg_w_r, cfg_w_nxt;
  logic [SIZE_W-1:0]     cfg_h_r, cfg_h_nxt;
  logic [CHAR_W-1:0]     blank_r, blank_nxt;
  logic                  out_valid_r, out_valid_nxt;
  out_beat_t             out_data_r, out_data_nxt;

  logic signed [7:0]     cur_x_r, cur_x_nxt;
  logic signed [7:0]     cur_y_r, cur_y_nxt;
  logic signed [7:0]     x_lo_r, x_lo_nxt;
  logic signed [7:0]     x_hi_r, x_hi_nxt;
  logic signed [7:0]     y_lo_r, y_lo_nxt;
  logic signed [7:0]     y_hi_r, y_hi_nxt;
  logic signed [7:0]     cx_r, cx_nxt;
  logic signed [7:0]     cy_r, cy_nxt;
  logic [11:0]           r_sq_r, r_sq_nxt;
  logic [CHAR_W-1:0]     pen_r, pen_nxt;
  shape_t                shape_r, shape_nxt;
  logic                  clip_r, clip_nxt;
  logic [CHAR_W-1:0]     res_val_r, res_val_nxt;
  logic [STATUS_W-1:0]   res_st_r, res_st_nxt;
  logic [CHAR_W-1:0]     rd_data_r;

  in_beat_t              beat;
  logic [SIZE_W-1:0]     act_w, act_h;
  logic                  in_area, hit;
  logic signed [8:0]     dx, dy;
  logic signed [17:0]    dx_sq_f, dy_sq_f;
  logic [11:0]           dx_sq, dy_sq;
  logic [12:0]           dist_sq;
  logic [11:0]           rad12;
  logic signed [7:0]     x1e, y1e, x2e, y2e, re;
  logic [AW-1:0]         scan_addr, rd_addr;
  logic                  mem_we;
  logic [AW-1:0]         mem_waddr;
  logic [CHAR_W-1:0]     mem_wdata;

  assign beat       = in_beat_t'(in_tdata[$bits(in_beat_t)-1:0]);
  assign in_tready  = (state_r == S_IDLE);
  assign cfg_ready  = 1'b1;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OUT_DATA_W - $bits(out_beat_t)){1'b0}}, out_data_r};

  always_comb begin
    if (cfg_w_r == '0) begin
      act_w = SIZE_W'(1);
    end else if (int'(cfg_w_r) > int'(MAX_WIDTH)) begin
      act_w = SIZE_W'(MAX_WIDTH);
    end else begin
      act_w = cfg_w_r;
    end
    if (cfg_h_r == '0) begin
      act_h = SIZE_W'(1);
    end else if (int'(cfg_h_r) > int'(MAX_HEIGHT)) begin
      act_h = SIZE_W'(MAX_HEIGHT);
    end else begin
      act_h = cfg_h_r;
    end
  end

  assign x1e   = {2'b00, beat.x_first};
  assign y1e   = {2'b00, beat.y_first};
  assign x2e   = {2'b00, beat.x_second};
  assign y2e   = {2'b00, beat.y_second};
  assign re    = {2'b00, beat.radius};
  assign rad12 = {6'b000000, beat.radius};

  assign dx      = {cur_x_r[7], cur_x_r} - {cx_r[7], cx_r};
  assign dy      = {cur_y_r[7], cur_y_r} - {cy_r[7], cy_r};
  assign dx_sq_f = dx * dx;
  assign dy_sq_f = dy * dy;
  assign dx_sq   = dx_sq_f[11:0];
  assign dy_sq   = dy_sq_f[11:0];
  assign dist_sq = {1'b0, dx_sq} + {1'b0, dy_sq};

  assign in_area = !cur_x_r[7] && !cur_y_r[7] &&
                   (cur_x_r[6:0] < act_w) && (cur_y_r[6:0] < act_h);

  always_comb begin
    case (shape_r)
      SH_FILL:    hit = 1'b1;
      SH_OUTLINE: hit = (cur_x_r == x_lo_r) || (cur_x_r == x_hi_r) ||
                        (cur_y_r == y_lo_r) || (cur_y_r == y_hi_r);
      SH_CIRCLE:  hit = (dist_sq < {1'b0, r_sq_r});
      default:    hit = 1'b0;
    endcase
  end

  assign scan_addr = AW'(AW'(cur_y_r[6:0]) * AW'(MAX_WIDTH) + AW'(cur_x_r[6:0]));
  assign rd_addr   = AW'(AW'(beat.y_first) * AW'(MAX_WIDTH) + AW'(beat.x_first));

  always_comb begin
    state_nxt     = state_r;
    init_addr_nxt = init_addr_r;
    cfg_w_nxt     = cfg_w_r;
    cfg_h_nxt     = cfg_h_r;
    blank_nxt     = blank_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    cur_x_nxt     = cur_x_r;
    cur_y_nxt     = cur_y_r;
    x_lo_nxt      = x_lo_r;
    x_hi_nxt      = x_hi_r;
    y_lo_nxt      = y_lo_r;
    y_hi_nxt      = y_hi_r;
    cx_nxt        = cx_r;
    cy_nxt        = cy_r;
    r_sq_nxt      = r_sq_r;
    pen_nxt       = pen_r;
    shape_nxt     = shape_r;
    clip_nxt      = clip_r;
    res_val_nxt   = res_val_r;
    res_st_nxt    = res_st_r;
    mem_we        = 1'b0;
    mem_waddr     = scan_addr;
    mem_wdata     = pen_r;

    if (cfg_valid) begin
      case (cfg_index)
        CFG_WIDTH:  cfg_w_nxt = cfg_data[SIZE_W-1:0];
        CFG_HEIGHT: cfg_h_nxt = cfg_data[SIZE_W-1:0];
        CFG_BLANK:  blank_nxt = cfg_data;
        default:    ;
      endcase
    end

    if (out_tready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_INIT: begin
        mem_we    = 1'b1;
        mem_waddr = init_addr_r;
        mem_wdata = BLANK_RESET;
        if (init_addr_r == AW'(DEPTH - 1)) begin
          state_nxt = S_IDLE;
        end else begin
          init_addr_nxt = init_addr_r + AW'(1);
        end
      end
      S_IDLE: begin
        if (in_tvalid) begin
          clip_nxt    = 1'b0;
          pen_nxt     = beat.pen_char;
          cx_nxt      = x1e;
          cy_nxt      = y1e;
          r_sq_nxt    = rad12 * rad12;
          res_val_nxt = '0;
          res_st_nxt  = ST_OK;
          shape_nxt   = SH_FILL;
          x_lo_nxt    = x1e;
          x_hi_nxt    = x1e;
          y_lo_nxt    = y1e;
          y_hi_nxt    = y1e;
          cur_x_nxt   = x1e;
          cur_y_nxt   = y1e;
          state_nxt   = S_SCAN;
          case (in_tuser)
            OP_POINT: ;
            OP_FILL, OP_OUTLINE: begin
              x_hi_nxt  = x2e;
              y_hi_nxt  = y2e;
              shape_nxt = (in_tuser == OP_FILL) ? SH_FILL : SH_OUTLINE;
              if (beat.x_first > beat.x_second || beat.y_first > beat.y_second) begin
                res_st_nxt = ST_EMPTY;
                state_nxt  = S_DONE;
              end
            end
            OP_CIRCLE: begin
              shape_nxt = SH_CIRCLE;
              x_lo_nxt  = x1e - re;
              x_hi_nxt  = x1e + re;
              y_lo_nxt  = y1e - re;
              y_hi_nxt  = y1e + re;
              cur_x_nxt = x1e - re;
              cur_y_nxt = y1e - re;
            end
            OP_CLEAR: begin
              pen_nxt   = blank_r;
              x_lo_nxt  = '0;
              y_lo_nxt  = '0;
              cur_x_nxt = '0;
              cur_y_nxt = '0;
              x_hi_nxt  = {1'b0, act_w} - 8'sd1;
              y_hi_nxt  = {1'b0, act_h} - 8'sd1;
            end
            OP_READ: state_nxt = S_READ;
            default: state_nxt = S_DONE;
          endcase
        end
      end
      S_SCAN: begin
        mem_we = hit && in_area;
        if (hit && !in_area) begin
          clip_nxt = 1'b1;
        end
        if (cur_x_r == x_hi_r) begin
          cur_x_nxt = x_lo_r;
          if (cur_y_r == y_hi_r) begin
            state_nxt  = S_DONE;
            res_st_nxt = (clip_r || (hit && !in_area)) ? ST_CLIP : ST_OK;
          end else begin
            cur_y_nxt = cur_y_r + 8'sd1;
          end
        end else begin
          cur_x_nxt = cur_x_r + 8'sd1;
        end
      end
      S_READ: begin
        if (in_area) begin
          res_val_nxt = rd_data_r;
        end else begin
          res_st_nxt = ST_CLIP;
        end
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt           = 1'b1;
          out_data_nxt.read_value = res_val_r;
          out_data_nxt.status     = res_st_r;
          state_nxt               = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_INIT;
      init_addr_r <= '0;
      cfg_w_r     <= WIDTH_RESET;
      cfg_h_r     <= HEIGHT_RESET;
      blank_r     <= BLANK_RESET;
      out_valid_r <= 1'b0;
      clip_r      <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      init_addr_r <= init_addr_nxt;
      cfg_w_r     <= cfg_w_nxt;
      cfg_h_r     <= cfg_h_nxt;
      blank_r     <= blank_nxt;
      out_valid_r <= out_valid_nxt;
      clip_r      <= clip_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
    cur_x_r    <= cur_x_nxt;
    cur_y_r    <= cur_y_nxt;
    x_lo_r     <= x_lo_nxt;
    x_hi_r     <= x_hi_nxt;
    y_lo_r     <= y_lo_nxt;
    y_hi_r     <= y_hi_nxt;
    cx_r       <= cx_nxt;
    cy_r       <= cy_nxt;
    r_sq_r     <= r_sq_nxt;
    pen_r      <= pen_nxt;
    shape_r    <= shape_nxt;
    res_val_r  <= res_val_nxt;
    res_st_r   <= res_st_nxt;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd_data_r <= mem[rd_addr];
  end

endmodule
